>>> src/bmm_pkg.sv
// Shared types, sizes and codes of the batched matrix multiply block.
package bmm_pkg;

  localparam int MAX_BATCH = 4;
  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 16;
  localparam int MAX_COLS  = 16;

  localparam int BATCH_W = $clog2(MAX_BATCH);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int INNER_W = $clog2(MAX_INNER);
  localparam int COL_W   = $clog2(MAX_COLS);

  localparam int BATCH_CNT_W = 3;
  localparam int DIM_CNT_W   = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int DATA_W      = 32;

  localparam int LEFT_DEPTH  = MAX_BATCH * MAX_ROWS * MAX_INNER;
  localparam int RIGHT_DEPTH = MAX_BATCH * MAX_INNER * MAX_COLS;
  localparam int LEFT_AW     = $clog2(LEFT_DEPTH);
  localparam int RIGHT_AW    = $clog2(RIGHT_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE_LEFT  = 2'd0,
    OP_WRITE_RIGHT = 2'd1,
    OP_COMPUTE     = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BATCH_COUNT = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_INNER_COUNT = 2'd2,
    REG_COL_COUNT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [1:0]               batch_index;
    logic [3:0]               row_index;
    logic [3:0]               col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     index_error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic load_out;
  } bmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_mac;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } bmm_stat_t;

endpackage

>>> src/bmm_ctrl.sv
// Controller state machine of the batched matrix multiply block.
module bmm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmm_pkg::bmm_stat_t stat,
  output bmm_pkg::bmm_cmd_t  cmd
);
  import bmm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.needs_mac ? S_MAC : S_FINISH;
        end
      end
      S_MAC: begin
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_MAC:    cmd.issue = 1'b1;
      S_DRAIN:  cmd.issue = 1'b0;
      S_FINISH: cmd.load_out = stat.out_free;
      default:  in_ready = 1'b0;
    endcase
  end

endmodule

>>> src/bmm_datapath.sv
// Datapath: configuration registers, matrix stores, multiply-accumulate and output register.
module bmm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bmm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bmm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  bmm_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bmm_pkg::out_item_t                  out_item,
  input  bmm_pkg::bmm_cmd_t                   cmd,
  output bmm_pkg::bmm_stat_t                  stat
);
  import bmm_pkg::*;

  logic [BATCH_CNT_W-1:0] batch_count;
  logic [DIM_CNT_W-1:0]   row_count;
  logic [DIM_CNT_W-1:0]   inner_count;
  logic [DIM_CNT_W-1:0]   col_count;

  logic [BATCH_CNT_W-1:0] nb;
  logic [DIM_CNT_W-1:0]   nr;
  logic [DIM_CNT_W-1:0]   nk;
  logic [DIM_CNT_W-1:0]   nc;

  logic b_ok, r_row_ok, r_inner_ok, c_inner_ok, c_col_ok;
  logic left_ok, right_ok, comp_ok, in_err;

  logic [BATCH_W-1:0] b_q;
  logic [ROW_W-1:0]   r_q;
  logic [COL_W-1:0]   c_q;
  logic               err_q;
  logic [INNER_W-1:0] k;

  logic [DATA_W-1:0] left_mem  [LEFT_DEPTH];
  logic [DATA_W-1:0] right_mem [RIGHT_DEPTH];
  logic [DATA_W-1:0] ldata;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic              rd_valid;
  logic              prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count <= BATCH_CNT_W'(1);
      row_count   <= DIM_CNT_W'(16);
      inner_count <= DIM_CNT_W'(16);
      col_count   <= DIM_CNT_W'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BATCH_COUNT: batch_count <= cfg_wdata[BATCH_CNT_W-1:0];
        REG_ROW_COUNT:   row_count   <= cfg_wdata[DIM_CNT_W-1:0];
        REG_INNER_COUNT: inner_count <= cfg_wdata[DIM_CNT_W-1:0];
        REG_COL_COUNT:   col_count   <= cfg_wdata[DIM_CNT_W-1:0];
        default:         batch_count <= batch_count;
      endcase
    end
  end

  // A register above its size limit acts as the limit.
  always_comb begin
    nb = (batch_count > BATCH_CNT_W'(MAX_BATCH)) ? BATCH_CNT_W'(MAX_BATCH) : batch_count;
    nr = (row_count > DIM_CNT_W'(MAX_ROWS)) ? DIM_CNT_W'(MAX_ROWS) : row_count;
    nk = (inner_count > DIM_CNT_W'(MAX_INNER)) ? DIM_CNT_W'(MAX_INNER) : inner_count;
    nc = (col_count > DIM_CNT_W'(MAX_COLS)) ? DIM_CNT_W'(MAX_COLS) : col_count;
  end

  always_comb begin
    b_ok       = BATCH_CNT_W'(in_item.batch_index) < nb;
    r_row_ok   = DIM_CNT_W'(in_item.row_index) < nr;
    r_inner_ok = DIM_CNT_W'(in_item.row_index) < nk;
    c_inner_ok = DIM_CNT_W'(in_item.col_index) < nk;
    c_col_ok   = DIM_CNT_W'(in_item.col_index) < nc;
    left_ok    = b_ok && r_row_ok && c_inner_ok;
    right_ok   = b_ok && r_inner_ok && c_col_ok;
    comp_ok    = b_ok && r_row_ok && c_col_ok;
    case (op_t'(in_item.operation))
      OP_WRITE_LEFT:  in_err = !left_ok;
      OP_WRITE_RIGHT: in_err = !right_ok;
      OP_COMPUTE:     in_err = !comp_ok;
      default:        in_err = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      b_q   <= in_item.batch_index;
      r_q   <= in_item.row_index;
      c_q   <= in_item.col_index;
      err_q <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + INNER_W'(1);
    end
  end

  // Writes land in the stores in the cycle the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(in_item.operation) == OP_WRITE_LEFT && left_ok) begin
      left_mem[{in_item.batch_index, in_item.row_index, in_item.col_index}] <=
        in_item.element_value;
    end
    if (cmd.issue) begin
      ldata <= left_mem[{b_q, r_q, k}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(in_item.operation) == OP_WRITE_RIGHT && right_ok) begin
      right_mem[{in_item.batch_index, in_item.row_index, in_item.col_index}] <=
        in_item.element_value;
    end
    if (cmd.issue) begin
      rdata <= right_mem[{b_q, k, c_q}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  // The low word of the product is the same for signed and unsigned operands.
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= ldata * rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.result_value <= acc;
      out_item.index_error  <= err_q;
    end
  end

  always_comb begin
    stat.needs_mac  = op_t'(in_item.operation) == OP_COMPUTE && comp_ok &&
                      nk != '0;
    stat.last_issue = DIM_CNT_W'(k) == nk - DIM_CNT_W'(1);
    stat.pipe_empty = !rd_valid && !prod_valid;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

>>> src/batched_matrix_multiply.sv
// Top level of the batched matrix multiply block.
// Write transactions store one element of a left or right matrix; a compute
// transaction sends one store read and one multiply-accumulate through the datapath
// per inner index, for nk indices where nk is inner_count limited to MAX_INNER, and then
// drains the read, multiply and accumulate registers. Items that fail the index check,
// and computes with an inner size of zero, skip the multiply-accumulate. The result sits
// in an output register, so the block returns to accept the next transaction as soon as
// that register is free to load. Store entries hold no defined value until written and
// no clearing pass runs after reset.
module batched_matrix_multiply (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmm_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bmm_pkg::out_item_t             out_item
);
  import bmm_pkg::*;

  bmm_cmd_t  cmd;
  bmm_stat_t stat;

  bmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> test/bmm_checker.sv
// Checker for the batched matrix multiply block: mirrors its stores and compares every result.
module bmm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  bmm_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  bmm_pkg::out_item_t             out_item,
  output int                             pending,
  output int                             failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmm_pkg::*;

  logic [DATA_W-1:0]      left_mem  [LEFT_DEPTH];
  logic [DATA_W-1:0]      right_mem [RIGHT_DEPTH];
  logic [BATCH_CNT_W-1:0] batch_reg;
  logic [DIM_CNT_W-1:0]   row_reg;
  logic [DIM_CNT_W-1:0]   inner_reg;
  logic [DIM_CNT_W-1:0]   col_reg;
  out_item_t              expected_results [$];
  out_item_t              oldest;
  int                     fail_total = 0;
  int                     reported = 0;

  function automatic int clamp(int value, int cap);
    return (value < cap) ? value : cap;
  endfunction

  // Applies one transaction to the mirrored stores and returns the result it should produce.
  function automatic out_item_t matmul_step(in_item_t it);
    int                nb;
    int                nr;
    int                nk;
    int                nc;
    int                b;
    int                r;
    int                c;
    logic [DATA_W-1:0] acc;
    out_item_t         res;
    nb = clamp(int'(batch_reg), MAX_BATCH);
    nr = clamp(int'(row_reg), MAX_ROWS);
    nk = clamp(int'(inner_reg), MAX_INNER);
    nc = clamp(int'(col_reg), MAX_COLS);
    b = int'(it.batch_index);
    r = int'(it.row_index);
    c = int'(it.col_index);
    acc = '0;
    res.index_error = 1'b0;
    case (it.operation)
      OP_WRITE_LEFT: begin
        if (b < nb && r < nr && c < nk) begin
          left_mem[(b * MAX_ROWS + r) * MAX_INNER + c] = it.element_value;
        end else begin
          res.index_error = 1'b1;
        end
      end
      OP_WRITE_RIGHT: begin
        if (b < nb && r < nk && c < nc) begin
          right_mem[(b * MAX_INNER + r) * MAX_COLS + c] = it.element_value;
        end else begin
          res.index_error = 1'b1;
        end
      end
      OP_COMPUTE: begin
        if (b < nb && r < nr && c < nc) begin
          for (int k = 0; k < nk; k++) begin
            acc += left_mem[(b * MAX_ROWS + r) * MAX_INNER + k] *
                   right_mem[(b * MAX_INNER + k) * MAX_COLS + c];
          end
        end else begin
          res.index_error = 1'b1;
        end
      end
      default: ;
    endcase
    res.result_value = acc;
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_total++;
    if (reported < 10) begin
      reported++;
      $display("bmm_checker: %s", msg);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      batch_reg = BATCH_CNT_W'(1);
      row_reg   = DIM_CNT_W'(16);
      inner_reg = DIM_CNT_W'(16);
      col_reg   = DIM_CNT_W'(16);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: value %h, error %b",
                                 out_item.result_value, out_item.index_error));
        end else begin
          oldest = expected_results.pop_front();
          if (out_item.result_value !== oldest.result_value) begin
            note_failure($sformatf("result_value expected %h, got %h",
                                   oldest.result_value, out_item.result_value));
          end
          if (out_item.index_error !== oldest.index_error) begin
            note_failure($sformatf("index_error expected %b, got %b",
                                   oldest.index_error, out_item.index_error));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_BATCH_COUNT: batch_reg = cfg_wdata[BATCH_CNT_W-1:0];
          REG_ROW_COUNT:   row_reg   = cfg_wdata[DIM_CNT_W-1:0];
          REG_INNER_COUNT: inner_reg = cfg_wdata[DIM_CNT_W-1:0];
          REG_COL_COUNT:   col_reg   = cfg_wdata[DIM_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(matmul_step(in_item));
      end
    end
    pending  <= expected_results.size();
    failures <= fail_total;
  end

endmodule

>>> test/tb_top.sv
// Top of the batched matrix multiply testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmm_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 160;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  int                    pending;
  int                    failures;
  int                    cycles = 0;
  bit                    calm = 1'b0;

  // Sizes in force, already clamped to the store dimensions.
  int lim_b = 1;
  int lim_r = 16;
  int lim_k = 16;
  int lim_c = 16;
  int items_sent = 0;

  // Store entries written so far; a compute never reads one that is still unset.
  bit left_written  [LEFT_DEPTH];
  bit right_written [RIGHT_DEPTH];

  batched_matrix_multiply i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  bmm_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .pending   (pending),
    .failures  (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int clamp(int value, int cap);
    return (value < cap) ? value : cap;
  endfunction

  function automatic int left_addr(int b, int i, int k);
    return (b * MAX_ROWS + i) * MAX_INNER + k;
  endfunction

  function automatic int right_addr(int b, int k, int j);
    return (b * MAX_INNER + k) * MAX_COLS + j;
  endfunction

  function automatic in_item_t make_item(op_t op, int b, int r, int c, logic [DATA_W-1:0] v);
    in_item_t it;
    it.operation     = op;
    it.batch_index   = 2'(b);
    it.row_index     = 4'(r);
    it.col_index     = 4'(c);
    it.element_value = v;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly an index inside the configured size, sometimes anywhere in the field.
  function automatic int pick(int lim, int span);
    if (lim > 0 && $urandom_range(0, 99) < 85) begin
      return $urandom_range(0, lim - 1);
    end
    return $urandom_range(0, span - 1);
  endfunction

  function automatic bit in_bounds(in_item_t it);
    int b;
    int r;
    int c;
    b = int'(it.batch_index);
    r = int'(it.row_index);
    c = int'(it.col_index);
    case (it.operation)
      OP_WRITE_LEFT:  return b < lim_b && r < lim_r && c < lim_k;
      OP_WRITE_RIGHT: return b < lim_b && r < lim_k && c < lim_c;
      OP_COMPUTE:     return b < lim_b && r < lim_r && c < lim_c;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic in_item_t random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      return make_item(OP_COMPUTE, pick(lim_b, MAX_BATCH), pick(lim_r, MAX_ROWS),
                       pick(lim_c, MAX_COLS), rand_value());
    end else if (sel < 66) begin
      return make_item(OP_WRITE_LEFT, pick(lim_b, MAX_BATCH), pick(lim_r, MAX_ROWS),
                       pick(lim_k, MAX_INNER), rand_value());
    end else if (sel < 95) begin
      return make_item(OP_WRITE_RIGHT, pick(lim_b, MAX_BATCH), pick(lim_k, MAX_INNER),
                       pick(lim_c, MAX_COLS), rand_value());
    end
    return make_item(OP_NONE, $urandom_range(0, 3), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom);
  endfunction

  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tracked(in_item_t it);
    if (in_bounds(it)) begin
      if (it.operation == OP_WRITE_LEFT) begin
        left_written[left_addr(it.batch_index, it.row_index, it.col_index)] = 1'b1;
      end else if (it.operation == OP_WRITE_RIGHT) begin
        right_written[right_addr(it.batch_index, it.row_index, it.col_index)] = 1'b1;
      end
    end
    send_item(it);
    items_sent++;
  endtask

  // A compute inside the sizes is preceded by writes of any operand entry still unset.
  task automatic issue(in_item_t it);
    int b;
    int r;
    int c;
    b = int'(it.batch_index);
    r = int'(it.row_index);
    c = int'(it.col_index);
    if (it.operation == OP_COMPUTE && in_bounds(it)) begin
      for (int k = 0; k < lim_k; k++) begin
        if (!left_written[left_addr(b, r, k)]) begin
          send_tracked(make_item(OP_WRITE_LEFT, b, r, k, rand_value()));
        end
        if (!right_written[right_addr(b, k, c)]) begin
          send_tracked(make_item(OP_WRITE_RIGHT, b, k, c, rand_value()));
        end
      end
    end
    send_tracked(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_sizes(int nb, int nr, int nk, int nc);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BATCH_COUNT;
    cfg_wdata <= CFG_DATA_W'(nb);
    @(posedge clk);
    cfg_addr  <= REG_ROW_COUNT;
    cfg_wdata <= CFG_DATA_W'(nr);
    @(posedge clk);
    cfg_addr  <= REG_INNER_COUNT;
    cfg_wdata <= CFG_DATA_W'(nk);
    @(posedge clk);
    cfg_addr  <= REG_COL_COUNT;
    cfg_wdata <= CFG_DATA_W'(nc);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_b = clamp(nb & 7, MAX_BATCH);
    lim_r = clamp(nr & 31, MAX_ROWS);
    lim_k = clamp(nk & 31, MAX_INNER);
    lim_c = clamp(nc & 31, MAX_COLS);
  endtask

  task automatic run_phase(int nb, int nr, int nk, int nc);
    int target;
    set_sizes(nb, nr, nk, nc);
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      // One stretch of the run goes without any idle cycles on either side.
      calm = (items_sent >= 500 && items_sent < 700);
      if ($urandom_range(0, 59) == 0) begin
        drain();
      end
      issue(random_item());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: one matrix pair of 16 by 16.
    issue(make_item(OP_WRITE_LEFT, 0, 15, 15, 32'h7fff_ffff));
    issue(make_item(OP_WRITE_LEFT, 3, 0, 0, 32'h0000_0005));
    issue(make_item(OP_WRITE_RIGHT, 0, 15, 15, 32'h8000_0000));
    issue(make_item(OP_WRITE_RIGHT, 1, 15, 15, 32'hffff_ffff));
    issue(make_item(OP_COMPUTE, 2, 0, 0, 32'h0));
    issue(make_item(OP_NONE, 3, 15, 15, 32'hffff_ffff));
    issue(make_item(OP_NONE, 0, 0, 0, 32'h0));

    // Short inner dimension so that extreme products can be checked quickly.
    set_sizes(4, 16, 2, 16);
    issue(make_item(OP_WRITE_LEFT, 3, 15, 0, 32'h8000_0000));
    issue(make_item(OP_WRITE_LEFT, 3, 15, 1, 32'h7fff_ffff));
    issue(make_item(OP_WRITE_RIGHT, 3, 0, 15, 32'hffff_ffff));
    issue(make_item(OP_WRITE_RIGHT, 3, 1, 15, 32'h7fff_ffff));
    issue(make_item(OP_COMPUTE, 3, 15, 15, 32'hffff_ffff));
    issue(make_item(OP_WRITE_LEFT, 0, 0, 0, 32'hffff_ffff));
    issue(make_item(OP_WRITE_LEFT, 0, 0, 1, 32'hffff_ffff));
    issue(make_item(OP_WRITE_RIGHT, 0, 0, 0, 32'hffff_ffff));
    issue(make_item(OP_WRITE_RIGHT, 0, 1, 0, 32'h0000_0001));
    issue(make_item(OP_COMPUTE, 0, 0, 0, 32'h0));
    issue(make_item(OP_WRITE_LEFT, 1, 4, 2, 32'h1234_5678));
    issue(make_item(OP_WRITE_RIGHT, 2, 2, 3, 32'h8765_4321));

    // An empty inner dimension sums over no terms.
    set_sizes(4, 16, 0, 16);
    issue(make_item(OP_COMPUTE, 1, 5, 7, 32'h0));

    run_phase(1, 16, 16, 16);
    run_phase(4, 16, 16, 16);
    run_phase(7, 31, 31, 31);
    run_phase(1, 1, 1, 1);
    run_phase(2, 3, 0, 5);
    run_phase(0, 8, 4, 8);
    repeat (3) begin
      run_phase($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31));
    end

    drain();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
